// ----- design/gmcp_pkg.sv -----
// Shared constants, state and interface types of the grid minimum-cost path search.
package gmcp_pkg;

  // Default grid side length.
  localparam int DEF_GRID_SIDE = 5;

  // Fixed field widths.
  localparam int COST_W = 8;
  localparam int SUM_W  = 16;
  localparam int MAP_W  = 25;

  // Move codes, tried in this order; DIR_END means every move was tried.
  localparam int DIR_W = 3;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_END   = 3'd4;

  // Controller states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT_RD,
    ST_INIT,
    ST_CHECK,
    ST_FETCH,
    ST_BACK,
    ST_POP,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;
    logic init_rd;
    logic init_set;
    logic dir_next;
    logic nb_rd;
    logic push;
    logic stk_rd;
    logic pop;
    logic record;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_load;
    logic at_target;
    logic dir_end;
    logic nb_open;
    logic nb_zero;
    logic stk_empty;
    logic out_full;
  } sts_t;

endpackage

// ----- design/gmcp_ctrl.sv -----
// Controller state machine that sequences loading, backtracking search and result hand-off.
module gmcp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gmcp_pkg::sts_t sts_i,
  output gmcp_pkg::cmd_t cmd_o
);
  import gmcp_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_wr = 1'b1;
          if (sts_i.last_load) state_d = ST_INIT_RD;
        end
      end
      ST_INIT_RD: begin
        cmd_o.init_rd = 1'b1;
        state_d       = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init_set = 1'b1;
        state_d        = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.at_target) begin
          cmd_o.record = 1'b1;
          state_d      = ST_BACK;
        end else if (sts_i.dir_end) begin
          state_d = ST_BACK;
        end else if (sts_i.nb_open) begin
          cmd_o.nb_rd = 1'b1;
          state_d     = ST_FETCH;
        end else begin
          cmd_o.dir_next = 1'b1;
        end
      end
      ST_FETCH: begin
        // A wall is skipped; an open cell extends the walk.
        if (sts_i.nb_zero) begin
          cmd_o.dir_next = 1'b1;
        end else begin
          cmd_o.push = 1'b1;
        end
        state_d = ST_CHECK;
      end
      ST_BACK: begin
        if (sts_i.stk_empty) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.stk_rd = 1'b1;
          state_d      = ST_POP;
        end
      end
      ST_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = ST_CHECK;
      end
      ST_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

// ----- design/gmcp_dp.sv -----
// Datapath: cell cost memory, walk stack memory, walk registers and the result register.
module gmcp_dp #(
  parameter int GRID_SIDE = gmcp_pkg::DEF_GRID_SIDE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gmcp_pkg::cmd_t              cmd_i,
  output gmcp_pkg::sts_t              sts_o,
  input  logic [gmcp_pkg::COST_W-1:0] cell_cost_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gmcp_pkg::SUM_W-1:0]  min_cost_o,
  output logic [gmcp_pkg::MAP_W-1:0]  path_map_o,
  output logic                        found_o
);
  import gmcp_pkg::*;

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int RC_W  = $clog2(GRID_SIDE);
  localparam int IDX_W = $clog2(CELLS);
  localparam int STK_W = 2 * RC_W + DIR_W + COST_W;
  localparam logic [RC_W-1:0]  RC_LAST  = RC_W'(GRID_SIDE - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CELLS - 1);

  // Memories.
  logic [COST_W-1:0] cell_mem [CELLS];
  logic [STK_W-1:0]  stk_mem  [CELLS];
  logic [COST_W-1:0] cell_rd_q;
  logic [STK_W-1:0]  stk_rd_q;

  // Walk and result registers.
  logic [IDX_W-1:0] load_cnt_q;
  logic [RC_W-1:0]  row_q, col_q;
  logic [DIR_W-1:0] dir_q;
  logic [IDX_W-1:0] depth_q;
  logic [CELLS-1:0] visited_q;
  logic [CELLS-1:0] best_map_q;
  logic [SUM_W-1:0] best_cost_q;
  logic [SUM_W-1:0] run_cost_q;
  logic             found_q;
  logic             out_valid_q;
  logic [SUM_W-1:0] min_cost_q;
  logic [MAP_W-1:0] path_map_q;
  logic             out_found_q;

  // Neighbor selection.
  logic [RC_W-1:0]  nb_row, nb_col;
  logic             nb_inb;
  logic [IDX_W-1:0] nb_idx, cur_idx, cell_raddr;
  logic [RC_W-1:0]  pop_row, pop_col;
  logic [DIR_W-1:0] pop_dir;
  logic [COST_W-1:0] pop_cost;
  logic [CELLS+MAP_W-1:0] map_ext;

  always_comb begin
    nb_row = row_q;
    nb_col = col_q;
    nb_inb = 1'b0;
    case (dir_q)
      DIR_DOWN: begin
        nb_row = row_q + 1'b1;
        nb_inb = (row_q != RC_LAST);
      end
      DIR_UP: begin
        nb_row = row_q - 1'b1;
        nb_inb = (row_q != '0);
      end
      DIR_RIGHT: begin
        nb_col = col_q + 1'b1;
        nb_inb = (col_q != RC_LAST);
      end
      DIR_LEFT: begin
        nb_col = col_q - 1'b1;
        nb_inb = (col_q != '0);
      end
      default: begin
        nb_inb = 1'b0;
      end
    endcase
  end

  assign nb_idx  = IDX_W'(IDX_W'(nb_row) * IDX_W'(GRID_SIDE)) + IDX_W'(nb_col);
  assign cur_idx = IDX_W'(IDX_W'(row_q) * IDX_W'(GRID_SIDE)) + IDX_W'(col_q);
  assign cell_raddr = cmd_i.init_rd ? '0 : nb_idx;
  assign {pop_row, pop_col, pop_dir, pop_cost} = stk_rd_q;

  // Status toward the controller.
  always_comb begin
    sts_o           = '0;
    sts_o.last_load = (load_cnt_q == IDX_LAST);
    sts_o.at_target = (row_q == RC_LAST) && (col_q == RC_LAST);
    sts_o.dir_end   = (dir_q == DIR_END);
    sts_o.nb_open   = nb_inb && !visited_q[nb_idx];
    sts_o.nb_zero   = (cell_rd_q == '0);
    sts_o.stk_empty = (depth_q == '0);
    sts_o.out_full  = out_valid_q && !out_ready_i;
  end

  // Cell cost memory: written while loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) cell_mem[load_cnt_q] <= cell_cost_i;
    if (cmd_i.init_rd || cmd_i.nb_rd) cell_rd_q <= cell_mem[cell_raddr];
  end

  // Walk stack: parent position, move to resume at, and cost of the entered cell.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) stk_mem[depth_q] <= {row_q, col_q, dir_q + 1'b1, cell_rd_q};
    if (cmd_i.stk_rd) stk_rd_q <= stk_mem[depth_q - 1'b1];
  end

  // Load counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else if (cmd_i.load_wr) begin
      load_cnt_q <= sts_o.last_load ? '0 : load_cnt_q + 1'b1;
    end
  end

  // Walk state: start, extend, skip a move, step back, record a finished path and clear on result hand-off.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      dir_q       <= DIR_DOWN;
      depth_q     <= '0;
      visited_q   <= '0;
      best_map_q  <= '0;
      best_cost_q <= '1;
      run_cost_q  <= '0;
      found_q     <= 1'b0;
    end else begin
      if (cmd_i.init_set) begin
        row_q       <= '0;
        col_q       <= '0;
        dir_q       <= DIR_DOWN;
        depth_q     <= '0;
        visited_q   <= CELLS'(1);
        best_map_q  <= '0;
        best_cost_q <= '1;
        run_cost_q  <= SUM_W'(cell_rd_q);
        found_q     <= 1'b0;
      end
      if (cmd_i.dir_next) dir_q <= dir_q + 1'b1;
      if (cmd_i.push) begin
        row_q             <= nb_row;
        col_q             <= nb_col;
        dir_q             <= DIR_DOWN;
        depth_q           <= depth_q + 1'b1;
        visited_q[nb_idx] <= 1'b1;
        run_cost_q        <= run_cost_q + SUM_W'(cell_rd_q);
      end
      if (cmd_i.pop) begin
        row_q              <= pop_row;
        col_q              <= pop_col;
        dir_q              <= pop_dir;
        depth_q            <= depth_q - 1'b1;
        visited_q[cur_idx] <= 1'b0;
        run_cost_q         <= run_cost_q - SUM_W'(pop_cost);
      end
      if (cmd_i.record) begin
        found_q <= 1'b1;
        if (run_cost_q < best_cost_q) begin
          best_cost_q <= run_cost_q;
          best_map_q  <= visited_q;
        end
      end
      if (cmd_i.emit) begin
        visited_q   <= '0;
        best_map_q  <= '0;
        best_cost_q <= '1;
        run_cost_q  <= '0;
        found_q     <= 1'b0;
      end
    end
  end

  assign map_ext = {{MAP_W{1'b0}}, best_map_q};

  // Result register; it frees as soon as the receiver takes the transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      min_cost_q  <= found_q ? best_cost_q : '0;
      path_map_q  <= found_q ? map_ext[MAP_W-1:0] : '0;
      out_found_q <= found_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_cost_o  = min_cost_q;
  assign path_map_o  = path_map_q;
  assign found_o     = out_found_q;

endmodule

// ----- design/grid_min_cost_path_search.sv -----
// Top level of the grid minimum-cost path search: controller, datapath and stream ports.
//
// Usage: the slave stream carries one cell cost per transaction in row-major order,
// GRID_SIDE * GRID_SIDE transactions per grid; a cost of zero is a wall. After the
// last cell the block drops s_axis_tready and searches every simple path from the
// top-left to the bottom-right cell by backtracking (moves down, up, right, left).
// The master stream then carries one transaction: min_cost and path_map in tdata,
// found in tuser; with no path all three are zero.
// Throughput: one cell per cycle while loading. The search runs on a single
// sequencer with one read port on the cell memory and one on the walk stack:
// each move test is an ST_CHECK state, each read of a wall an ST_FETCH state, and each
// entered cell takes its read, the check that ends its moves and the step back (ST_BACK, ST_POP).
// Loading of the next grid starts the cycle after the result is placed.
// Stall: the result register holds the transaction until m_axis_tready; loading
// goes on meanwhile, and the next result waits until the register is free.
// Reset: asynchronous, active low; the block comes out ready to load a new grid.
module grid_min_cost_path_search #(
  parameter int GRID_SIDE = gmcp_pkg::DEF_GRID_SIDE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] cell_cost
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] min_cost, [40:16] path_map, [47:41] zero
  output logic        m_axis_tuser    // [0] found
);
  import gmcp_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [SUM_W-1:0] min_cost;
  logic [MAP_W-1:0] path_map;
  logic             found;

  gmcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gmcp_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cell_cost_i (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .min_cost_o  (min_cost),
    .path_map_o  (path_map),
    .found_o     (found)
  );

  // Pack the result fields.
  assign m_axis_tdata = {7'b0, path_map, min_cost};
  assign m_axis_tuser = found;

  // A result without a path carries all zeros.
  a_nopath_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("result without a path carries nonzero data");

  // A found path always contains the start cell and a nonzero minimum cost.
  a_path_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[16] && (m_axis_tdata[15:0] != '0))
    else $error("found path misses start cell or has zero cost");

  // A new result only appears at the end of a search, never while loading.
  a_result_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised while the block was loading");

endmodule
